// ===== hdl/rptd_pkg.sv =====
package rptd_pkg;

  // input item: pin edge or read request
  typedef struct packed {
    logic        cmd;
    logic        pin_level;
    logic [31:0] time_us;
  } in_item_t;

  // result item of a read
  typedef struct packed {
    logic [15:0]        pulse_width_us;
    logic signed [7:0]  throttle_percent;
    logic               braking;
    logic               had_new;
  } out_item_t;

  // command codes
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_PULSE     = 2'd0,
    CFG_MAX_PULSE     = 2'd1,
    CFG_NEUTRAL_PULSE = 2'd2,
    CFG_NEUTRAL_BAND  = 2'd3
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BAND_W     = 10;

  localparam logic [15:0]       MIN_PULSE_RST     = 16'd1000;
  localparam logic [15:0]       MAX_PULSE_RST     = 16'd2000;
  localparam logic [15:0]       NEUTRAL_PULSE_RST = 16'd1500;
  localparam logic [BAND_W-1:0] NEUTRAL_BAND_RST  = 10'd20;

  // signed working width for band edges and differences
  localparam int SW    = 18;
  // magnitude of a difference, dividend and divisor widths
  localparam int MAG_W = SW - 1;
  localparam int NUM_W = 24;
  localparam int DEN_W = MAG_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [6:0] THR_FULL = 7'd100;

  // read sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/rptd_div.sv =====
module rptd_div import rptd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in next dividend bit, try subtract
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem  <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem  <= trial[DEN_W-1:0];
      end
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/rc_pulse_throttle_decoder.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_item_t  (cmd, pin_level, time_us)
// out     | output    | out_valid/out_stall | out_item_t (width, throttle, braking, new)
// cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// an edge item gives no result
// a read item goes through setup, one multiply by 100, then a
// 24-step serial divider that produces one quotient bit per cycle
// the finished result sits in an output register, so edge items are taken
// while it waits; a second read waits until the register frees up
// rst is synchronous; configuration registers return to their defaults, no result pending
module rc_pulse_throttle_decoder import rptd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0]       min_pulse;
  logic [15:0]       max_pulse;
  logic [15:0]       neutral_pulse;
  logic [BAND_W-1:0] neutral_band;

  logic [31:0] rise_time;
  logic [15:0] pulse_width;
  logic        new_flag;

  state_t state, state_next;
  logic   in_acc;
  logic   div_start;
  logic   load_out;

  logic             had;
  logic             brk;
  logic             zero_thr;
  logic             neg;
  logic [MAG_W-1:0] diff_mag;
  logic [MAG_W-1:0] span_mag;
  logic [NUM_W-1:0] num;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  logic signed [SW-1:0] wv, lo, hi, mn, mx, from, to_end, diff, span;
  logic                 rev, in_band, upper, full_neg;
  logic [6:0]           mag;
  logic signed [7:0]    thr;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse     <= MIN_PULSE_RST;
      max_pulse     <= MAX_PULSE_RST;
      neutral_pulse <= NEUTRAL_PULSE_RST;
      neutral_band  <= NEUTRAL_BAND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_PULSE:     min_pulse     <= cfg_data;
        CFG_MAX_PULSE:     max_pulse     <= cfg_data;
        CFG_NEUTRAL_PULSE: neutral_pulse <= cfg_data;
        CFG_NEUTRAL_BAND:  neutral_band  <= cfg_data[BAND_W-1:0];
      endcase
    end
  end

  // edge capture and new-value flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time   <= '0;
      pulse_width <= '0;
      new_flag    <= 1'b0;
    end else if (in_acc) begin
      if (in_item.cmd == CMD_EDGE) begin
        if (in_item.pin_level) begin
          rise_time <= in_item.time_us;
        end else begin
          pulse_width <= in_item.time_us[15:0] - rise_time[15:0];
        end
        new_flag <= 1'b1;
      end else begin
        new_flag <= 1'b0;
      end
    end
  end

  // band edges and map endpoints
  always_comb begin
    wv       = SW'($signed({1'b0, pulse_width}));
    mn       = SW'($signed({1'b0, min_pulse}));
    mx       = SW'($signed({1'b0, max_pulse}));
    lo       = SW'($signed({1'b0, neutral_pulse})) - SW'($signed({1'b0, neutral_band}));
    hi       = SW'($signed({1'b0, neutral_pulse})) + SW'($signed({1'b0, neutral_band}));
    rev      = (min_pulse > max_pulse);
    in_band  = (wv < hi) && (wv > lo);
    upper    = (hi <= wv);
    from     = upper ? hi : lo;
    if (rev) begin
      to_end   = upper ? mn : mx;
      full_neg = upper;
    end else begin
      to_end   = upper ? mx : mn;
      full_neg = !upper;
    end
    diff = wv - from;
    span = to_end - from;
  end

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_item.cmd == CMD_READ) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-read working registers
  always_ff @(posedge clk) begin
    if (in_acc && in_item.cmd == CMD_READ) begin
      had <= new_flag;
    end
    if (state == ST_SETUP) begin
      brk      <= rev ? (wv > hi) : (wv < lo);
      zero_thr <= in_band || (span == '0);
      neg      <= diff[SW-1] ^ span[SW-1] ^ full_neg;
      diff_mag <= diff[SW-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      span_mag <= span[SW-1] ? MAG_W'(-span) : span[MAG_W-1:0];
    end
    if (state == ST_MUL) begin
      num <= NUM_W'(diff_mag) * NUM_W'(THR_FULL);
    end
  end

  rptd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span_mag),
    .done  (div_done),
    .quot  (div_quot)
  );

  // saturate and apply sign
  always_comb begin
    mag = (div_quot > NUM_W'(THR_FULL)) ? THR_FULL : div_quot[6:0];
    if (zero_thr) begin
      thr = '0;
    end else if (neg) begin
      thr = -$signed({1'b0, mag});
    end else begin
      thr = $signed({1'b0, mag});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.pulse_width_us   <= pulse_width;
      out_item.throttle_percent <= thr;
      out_item.braking          <= brk;
      out_item.had_new          <= had;
    end
  end

  // a read item starts the sequencer
  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.cmd == CMD_READ) |=> (state == ST_SETUP))
    else $error("read item did not start the sequencer");

  // a read item clears the new-value flag
  a_read_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.cmd == CMD_READ) |=> !new_flag)
    else $error("new flag still set after read");

  // results only appear from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result appeared outside done state");

  // throttle stays within full scale
  a_thr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.throttle_percent <= 8'sd100) &&
                   (out_item.throttle_percent >= -8'sd100)))
    else $error("throttle out of range");

endmodule
